FILE: rtl/psob_pkg.sv
// Shared types, codes and sine table math for the polyphonic sine oscillator bank.
package psob_pkg;

    localparam int ACTION_W = 3;
    localparam int SLOT_W = 3;
    localparam int FREQ_W = 23;
    localparam int RATE_W = 36;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W = 32;
    localparam int MUL_B_W = RATE_W / 2;
    localparam int PROD_W = FREQ_W + RATE_W;
    localparam int INC_SHIFT = 24;

    localparam logic [RATE_W-1:0] RATE_RESET = 36'd5864062015;

    localparam logic [ACTION_W-1:0] ACT_TICK = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ON = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_RETRIG = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OFF = 3'd4;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_EV_WRITE,
        ST_TK_READ,
        ST_TK_LOOK,
        ST_TK_ACC,
        ST_TK_OUT
    } state_t;

    // Magnitude of sin(2*pi*m/2^addr_bits) for m in the first quarter, Q15.
    function automatic logic [15:0] quarter_sine(input logic [31:0] m, input int addr_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] mag;
        x = (64'(m) * TWO_PI_Q30) >> addr_bits;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        p = ((x2 * t) >> 30) / 64'd156;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 64'd110;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 64'd72;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 64'd42;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 64'd20;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        p = ((x2 * t) >> 30) / 64'd6;
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
        s = (x * t) >> 30;
        mag = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return 16'(mag);
    endfunction

endpackage

FILE: rtl/polyphonic_sine_oscillator_bank_top.sv
// Top level: sequenced oscillator bank with shared multiplier, voice memory and sine ROM.
// Tick: each voice passes through the read, lookup and accumulate states in turn; then the
// output state registers the sum once no earlier result is held; new beats are taken in idle.
// On/retrigger: two 23x18 partial products, then the voice write.
// Off, unknown actions and out-of-range slots are handled in the idle state.
// Reset clears active flags, sequencer and output valid; inverse_rate resets to 5864062015.
module polyphonic_sine_oscillator_bank_top #(
    parameter int VOICES = 8,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slot[2:0], freq_q8[25:3], zero pad
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample[15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [35:0] cfg_data   // inverse_rate[35:0]
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int TABLE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int QUARTER = TABLE_SIZE / 4;
    localparam int ACC_W = 17 + $clog2(VOICES);
    localparam int WORD_W = 2 * psob_pkg::PHASE_W;
    localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    typedef logic signed [15:0] rom_t [TABLE_SIZE];

    function automatic rom_t build_rom();
        rom_t r;
        int k;
        int quad;
        int rem;
        int m;
        logic [15:0] v;
        for (k = 0; k < TABLE_SIZE; k++) begin
            quad = k / QUARTER;
            rem = k % QUARTER;
            m = ((quad % 2) == 1) ? (QUARTER - rem) : rem;
            v = psob_pkg::quarter_sine(32'(m), SINE_ADDR_BITS);
            r[k] = (quad >= 2) ? -v : v;
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    psob_pkg::state_t state_reg, state_next;

    logic [psob_pkg::RATE_W-1:0] rate_reg;
    logic [VOICES-1:0]           active_reg, active_next;
    logic [VIDX_W-1:0]           idx_reg, idx_next;
    logic [VIDX_W-1:0]           slot_reg, slot_next;
    logic [psob_pkg::FREQ_W-1:0] freq_reg, freq_next;
    logic [psob_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic                        en_reg, en_next;
    logic                        m_valid_reg, m_valid_next;
    logic [15:0]                 m_data_reg, m_data_next;

    logic [WORD_W-1:0]           voice_mem [VOICES];
    logic [WORD_W-1:0]           rd_data_reg;
    logic signed [15:0]          sine_reg;

    logic                        in_beat;
    logic [2:0]                  in_action;
    logic [VIDX_W-1:0]           in_slot;
    logic                        in_slot_ok;
    logic                        mem_we;
    logic [VIDX_W-1:0]           mem_waddr;
    logic [WORD_W-1:0]           mem_wdata;
    logic [psob_pkg::MUL_B_W-1:0] mul_b;
    logic [psob_pkg::FREQ_W+psob_pkg::MUL_B_W-1:0] mul_p;
    logic [psob_pkg::PHASE_W-1:0] rd_inc;
    logic [psob_pkg::PHASE_W-1:0] rd_phase;
    logic [psob_pkg::PHASE_W-1:0] new_inc;
    logic [15:0]                 sat_sample;
    logic                        out_free;

    assign s_tready = (state_reg == psob_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

    assign in_beat = s_tvalid && s_tready;
    assign in_action = s_tuser[2:0];
    assign in_slot = VIDX_W'(s_tdata[2:0]);
    assign in_slot_ok = ({4'b0, s_tdata[2:0]} < 7'(VOICES));

    assign rd_inc = rd_data_reg[WORD_W-1 -: psob_pkg::PHASE_W];
    assign rd_phase = rd_data_reg[psob_pkg::PHASE_W-1:0];
    assign out_free = !m_valid_reg || m_tready;

    assign mul_b = (state_reg == psob_pkg::ST_MUL_LO) ? rate_reg[psob_pkg::MUL_B_W-1:0]
                                                      : rate_reg[psob_pkg::RATE_W-1 -: psob_pkg::MUL_B_W];
    assign mul_p = freq_reg * mul_b;

    assign new_inc = (|prod_reg[psob_pkg::PROD_W-1:psob_pkg::INC_SHIFT+psob_pkg::PHASE_W])
                   ? {psob_pkg::PHASE_W{1'b1}}
                   : prod_reg[psob_pkg::INC_SHIFT +: psob_pkg::PHASE_W];

    always_comb begin
        if (acc_reg > SAT_HI) begin
            sat_sample = 16'h7fff;
        end else if (acc_reg < SAT_LO) begin
            sat_sample = 16'h8000;
        end else begin
            sat_sample = acc_reg[15:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psob_pkg::ST_IDLE: begin
                if (in_beat) begin
                    priority if (in_action == psob_pkg::ACT_TICK) begin
                        state_next = psob_pkg::ST_TK_READ;
                    end else if (in_slot_ok && (in_action == psob_pkg::ACT_ON ||
                                                in_action == psob_pkg::ACT_RETRIG)) begin
                        state_next = psob_pkg::ST_MUL_LO;
                    end else begin
                        state_next = psob_pkg::ST_IDLE;
                    end
                end
            end
            psob_pkg::ST_MUL_LO:   state_next = psob_pkg::ST_MUL_HI;
            psob_pkg::ST_MUL_HI:   state_next = psob_pkg::ST_EV_WRITE;
            psob_pkg::ST_EV_WRITE: state_next = psob_pkg::ST_IDLE;
            psob_pkg::ST_TK_READ:  state_next = psob_pkg::ST_TK_LOOK;
            psob_pkg::ST_TK_LOOK:  state_next = psob_pkg::ST_TK_ACC;
            psob_pkg::ST_TK_ACC: begin
                state_next = (idx_reg == LAST_IDX) ? psob_pkg::ST_TK_OUT : psob_pkg::ST_TK_READ;
            end
            psob_pkg::ST_TK_OUT: begin
                if (out_free) begin
                    state_next = psob_pkg::ST_IDLE;
                end
            end
            default: state_next = psob_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        active_next = active_reg;
        idx_next = idx_reg;
        slot_next = slot_reg;
        freq_next = freq_reg;
        prod_next = prod_reg;
        acc_next = acc_reg;
        en_next = en_reg;
        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = {rd_inc, rd_phase + rd_inc};
        unique case (state_reg)
            psob_pkg::ST_IDLE: begin
                if (in_beat) begin
                    slot_next = in_slot;
                    freq_next = s_tdata[3 +: psob_pkg::FREQ_W];
                    idx_next = '0;
                    acc_next = '0;
                    if (in_slot_ok && in_action == psob_pkg::ACT_OFF) begin
                        active_next[in_slot] = 1'b0;
                    end
                end
            end
            psob_pkg::ST_MUL_LO: begin
                prod_next = psob_pkg::PROD_W'(mul_p);
            end
            psob_pkg::ST_MUL_HI: begin
                prod_next = prod_reg + (psob_pkg::PROD_W'(mul_p) << psob_pkg::MUL_B_W);
            end
            psob_pkg::ST_EV_WRITE: begin
                mem_we = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = {new_inc, {psob_pkg::PHASE_W{1'b0}}};
                active_next[slot_reg] = 1'b1;
            end
            psob_pkg::ST_TK_READ: begin
            end
            psob_pkg::ST_TK_LOOK: begin
                en_next = active_reg[idx_reg] && (rd_inc != '0);
                mem_we = active_reg[idx_reg] && (rd_inc != '0);
            end
            psob_pkg::ST_TK_ACC: begin
                if (en_reg) begin
                    acc_next = acc_reg + ACC_W'(sine_reg >>> 3);
                end
                idx_next = idx_reg + VIDX_W'(1);
            end
            psob_pkg::ST_TK_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next = sat_sample;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= psob_pkg::ST_IDLE;
            rate_reg <= psob_pkg::RATE_RESET;
            active_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            active_reg <= active_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                rate_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        slot_reg <= slot_next;
        freq_reg <= freq_next;
        prod_reg <= prod_next;
        acc_reg <= acc_next;
        en_reg <= en_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            voice_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= voice_mem[idx_reg];
        sine_reg <= SINE_ROM[rd_phase[psob_pkg::PHASE_W-1 -: SINE_ADDR_BITS]];
    end

endmodule
